// File: rtl/llxy_pkg.sv
// ============================================================================
// llxy_pkg: shared types and constants of the lat/lon to screen projection
// Holds the register indexes, the stage payload types and the fixed-point
// constants of the projection and of the CORDIC engine.
// ============================================================================
`default_nettype none

package llxy_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_CENTER_LAT = 3'd0;
    localparam logic [2:0] REG_CENTER_LON = 3'd1;
    localparam logic [2:0] REG_MAP_SCALE  = 3'd2;
    localparam logic [2:0] REG_UP_DIR     = 3'd3;
    localparam logic [2:0] REG_SHIFT_DOWN = 3'd4;

    // Degree-to-metre weights, 1e-7 degree in radians, in Q0.40.
    localparam logic signed [29:0] K_LAT = 30'sd212126244;
    localparam logic signed [29:0] K_LON = 30'sd213624171;

    // CORDIC constants.
    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam int                 CORDIC_STEPS = 30;

    // Angle to binary phase: phase = a * 2^32 / 3600000000 with a in 1e-7
    // degree. Since 3600000000 = 2^10 * 3515625 this is a * 2^22 / 3515625,
    // estimated with floor(2^53 / 3515625) and fixed up by one subtraction.
    localparam logic [31:0] PHASE_RECIP = 32'd2562047788;
    localparam logic [21:0] PHASE_DIV   = 22'd3515625;
    // Tenths of a degree to 1e-7 degree.
    localparam logic [19:0] UP_TO_LAT   = 20'd1000000;

    typedef struct packed {
        logic signed [30:0] center_lat;
        logic signed [31:0] center_lon;
        logic [23:0]        map_scale;
        logic [11:0]        up_dir;
        logic signed [9:0]  shift_down;
    } t_cfg;

    typedef struct packed {
        logic signed [17:0] cos_lat;
        logic signed [17:0] cos_up;
        logic signed [17:0] sin_up;
    } t_trig;

    typedef struct packed {
        logic signed [31:0] dlat;
        logic signed [32:0] dlon;
    } t_diff;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               sat;
    } t_res;

    // Arctangent of 2^-i as a binary phase (2^32 per turn).
    function automatic logic [29:0] atan_phase(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2F9;
            5'd15: v = 30'h0000517C;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A2F;
            5'd19: v = 30'h00000517;
            5'd20: v = 30'h0000028B;
            5'd21: v = 30'h00000145;
            5'd22: v = 30'h000000A2;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000028;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000002;
            5'd29: v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/llxy_fifo.sv
// ============================================================================
// llxy_fifo: small synchronous queue
// Register-based queue with count; push and pop may happen in the same cycle.
// ============================================================================
`default_nettype none

module llxy_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_push,
    input  wire [WIDTH-1:0]           i_data,
    input  wire                       i_pop,
    output logic [WIDTH-1:0]          o_data,
    output logic                      o_full,
    output logic                      o_empty,
    output logic [$clog2(DEPTH):0]    o_count
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_wr, w_rd;

    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end

endmodule

`default_nettype wire

// File: rtl/llxy_trig.sv
// ============================================================================
// llxy_trig: configuration-time trigonometry
// Turns the centre latitude and the up angle into binary phases with a
// reciprocal multiply and one correction step, then runs a 30-step CORDIC
// to get cosines and sines.
// ============================================================================
`default_nettype none

module llxy_trig (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_lat,
    input  wire                 i_req_up,
    input  llxy_pkg::t_cfg      i_cfg,
    output llxy_pkg::t_trig     o_trig,
    output logic                o_busy
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_ROT  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_REM  = 3'd5;

    logic [2:0]         r_state, n_state;
    logic               r_pend_lat, n_pend_lat;
    logic               r_pend_up, n_pend_up;
    logic               r_sel, n_sel;
    logic               r_neg, n_neg;
    logic               r_flip, n_flip;
    logic [4:0]         r_cnt, n_cnt;
    logic [31:0]        r_a, n_a;
    logic [32:0]        r_q, n_q;
    logic [22:0]        r_rem, n_rem;
    logic signed [33:0] r_x, n_x;
    logic signed [33:0] r_y, n_y;
    logic signed [33:0] r_z, n_z;
    llxy_pkg::t_trig    r_trig, n_trig;

    logic signed [31:0] w_lat32;
    logic [63:0]        w_prod;
    logic [54:0]        w_qd;
    logic [54:0]        w_diff;
    logic [31:0]        w_q;
    logic [31:0]        w_phase;
    logic [31:0]        w_rot;
    logic signed [33:0] w_dx, w_dy, w_xr, w_yr;
    logic signed [19:0] w_c, w_s;

    function automatic logic signed [17:0] clamp_q16(input logic signed [19:0] v);
        logic signed [17:0] r;
        priority if (v > 20'sd65536) begin
            r = 18'sd65536;
        end else if (v < -20'sd65536) begin
            r = -18'sd65536;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    always_comb begin
        n_state    = r_state;
        n_pend_lat = r_pend_lat;
        n_pend_up  = r_pend_up;
        n_sel      = r_sel;
        n_neg      = r_neg;
        n_flip     = r_flip;
        n_cnt      = r_cnt;
        n_a        = r_a;
        n_q        = r_q;
        n_rem      = r_rem;
        n_x        = r_x;
        n_y        = r_y;
        n_z        = r_z;
        n_trig     = r_trig;

        // The quotient estimate is never high and at most one below the
        // true quotient, so one compare against the divisor finishes it.
        w_lat32 = 32'(i_cfg.center_lat);
        w_prod  = 64'(r_a) * 64'(llxy_pkg::PHASE_RECIP);
        w_qd    = 55'(r_q) * 55'(llxy_pkg::PHASE_DIV);
        w_diff  = {1'b0, r_a, 22'b0} - w_qd;
        w_q     = r_q[31:0] + 32'(r_rem >= {1'b0, llxy_pkg::PHASE_DIV});
        w_phase = r_neg ? -w_q : w_q;
        w_rot   = w_phase + 32'h4000_0000;
        w_dx    = r_y >>> r_cnt;
        w_dy    = r_x >>> r_cnt;
        w_xr    = (r_x + 34'sd8192) >>> 14;
        w_yr    = (r_y + 34'sd8192) >>> 14;
        w_c     = r_flip ? -w_xr[19:0] : w_xr[19:0];
        w_s     = r_flip ? -w_yr[19:0] : w_yr[19:0];

        unique case (r_state)
            ST_IDLE: begin
                if (r_pend_lat) begin
                    // The latitude phase truncates toward zero, so divide the
                    // magnitude and restore the sign afterwards.
                    n_pend_lat = 1'b0;
                    n_sel      = 1'b0;
                    n_neg      = i_cfg.center_lat[30];
                    n_a        = i_cfg.center_lat[30] ? -w_lat32 : w_lat32;
                    n_state    = ST_MUL;
                end else if (r_pend_up) begin
                    n_pend_up = 1'b0;
                    n_sel     = 1'b1;
                    n_neg     = 1'b0;
                    n_a       = 32'(i_cfg.up_dir) * 32'(llxy_pkg::UP_TO_LAT);
                    n_state   = ST_MUL;
                end
            end
            ST_MUL: begin
                n_q     = w_prod[63:31];
                n_state = ST_REM;
            end
            ST_REM: begin
                n_rem   = w_diff[22:0];
                n_state = ST_PREP;
            end
            ST_PREP: begin
                n_flip  = w_rot[31];
                n_z     = 34'($signed(w_rot[31] ? w_phase + 32'h8000_0000 : w_phase));
                n_x     = llxy_pkg::CORDIC_GAIN;
                n_y     = '0;
                n_cnt   = '0;
                n_state = ST_ROT;
            end
            ST_ROT: begin
                if (!r_z[33]) begin
                    n_x = r_x - w_dx;
                    n_y = r_y + w_dy;
                    n_z = r_z - 34'(llxy_pkg::atan_phase(r_cnt));
                end else begin
                    n_x = r_x + w_dx;
                    n_y = r_y - w_dy;
                    n_z = r_z + 34'(llxy_pkg::atan_phase(r_cnt));
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(llxy_pkg::CORDIC_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (r_sel) begin
                    n_trig.cos_up = clamp_q16(w_c);
                    n_trig.sin_up = clamp_q16(w_s);
                end else begin
                    n_trig.cos_lat = clamp_q16(w_c);
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A new write re-arms the computation even if one is under way.
        if (i_req_lat) begin
            n_pend_lat = 1'b1;
        end
        if (i_req_up) begin
            n_pend_up = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_pend_lat     <= 1'b0;
            r_pend_up      <= 1'b0;
            r_trig.cos_lat <= 18'sd65536;
            r_trig.cos_up  <= 18'sd65536;
            r_trig.sin_up  <= '0;
        end else begin
            r_state    <= n_state;
            r_pend_lat <= n_pend_lat;
            r_pend_up  <= n_pend_up;
            r_trig     <= n_trig;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel  <= n_sel;
        r_neg  <= n_neg;
        r_flip <= n_flip;
        r_cnt  <= n_cnt;
        r_a    <= n_a;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
    end

    assign o_trig = r_trig;
    assign o_busy = (r_state != ST_IDLE) || r_pend_lat || r_pend_up;

endmodule

`default_nettype wire

// File: rtl/llxy_front.sv
// ============================================================================
// llxy_front: input side of the projection
// Accepts points, forms the differences from the map centre and writes them
// into the queue toward the back end.
// ============================================================================
`default_nettype none

module llxy_front (
    input  wire                 i_push,
    input  wire signed [30:0]   i_point_latitude,
    input  wire signed [31:0]   i_point_longitude,
    input  llxy_pkg::t_cfg      i_cfg,
    input  wire                 i_trig_busy,
    input  wire                 i_q_full,
    output logic                o_full,
    output logic                o_q_push,
    output llxy_pkg::t_diff     o_diff
);

    // Points wait while the trigonometry is being recomputed.
    assign o_full      = i_q_full || i_trig_busy;
    assign o_q_push    = i_push && !o_full;
    assign o_diff.dlat = 32'(i_point_latitude) - 32'(i_cfg.center_lat);
    assign o_diff.dlon = 33'(i_point_longitude) - 33'(i_cfg.center_lon);

endmodule

`default_nettype wire

// File: rtl/llxy_back.sv
// ============================================================================
// llxy_back: projection pipeline
// Six-stage multiply pipeline: metre weighting, latitude cosine, scale,
// rotation, then truncation, screen translation and saturation.
// ============================================================================
`default_nettype none

module llxy_back #(
    parameter int SCREEN_W  = 240,
    parameter int SCREEN_H  = 320,
    parameter int OUT_DEPTH = 8
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  llxy_pkg::t_diff           i_diff,
    input  wire                       i_q_empty,
    output logic                      o_q_pop,
    input  llxy_pkg::t_cfg            i_cfg,
    input  llxy_pkg::t_trig           i_trig,
    input  wire [$clog2(OUT_DEPTH):0] i_out_count,
    output logic                      o_res_push,
    output llxy_pkg::t_res            o_res
);

    localparam int HALF_W = SCREEN_W / 2;
    localparam int HALF_H = SCREEN_H / 2;
    localparam int CW     = $clog2(OUT_DEPTH) + 1;

    logic [5:0]         r_vld;
    logic signed [31:0] r_a_dlat;
    logic signed [32:0] r_a_dlon;
    logic signed [37:0] r_b_ylat;
    logic signed [38:0] r_b_xlon;
    logic signed [40:0] r_c_xd;
    logic signed [37:0] r_c_ylat;
    logic signed [45:0] r_d_xs;
    logic signed [42:0] r_d_ys;
    logic signed [63:0] r_e_p1, r_e_p2, r_e_p3, r_e_p4;
    logic signed [64:0] r_f_rx, r_f_ry;

    logic signed [61:0] w_plat;
    logic signed [62:0] w_plon;
    logic signed [56:0] w_pxd;
    logic signed [65:0] w_pxs;
    logic signed [62:0] w_pys;
    logic signed [24:0] w_scale;
    logic signed [32:0] w_ix, w_iy;
    logic signed [34:0] w_sx;
    logic signed [35:0] w_sy;
    logic [CW-1:0]      w_owed;
    logic               w_sat_x, w_sat_y;

    // Issue only when the output queue has room for everything in flight.
    assign w_owed  = CW'($countones(r_vld)) + i_out_count;
    assign o_q_pop = !i_q_empty && (w_owed < CW'(OUT_DEPTH));

    assign w_plat  = 62'(r_a_dlat) * 62'(llxy_pkg::K_LAT);
    assign w_plon  = 63'(r_a_dlon) * 63'(llxy_pkg::K_LON);
    assign w_pxd   = 57'(r_b_xlon) * 57'(i_trig.cos_lat);
    assign w_scale = $signed({1'b0, i_cfg.map_scale});
    assign w_pxs   = 66'(r_c_xd) * 66'(w_scale);
    assign w_pys   = 63'(r_c_ylat) * 63'(w_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], o_q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_dlat <= i_diff.dlat;
        r_a_dlon <= i_diff.dlon;
        r_b_ylat <= w_plat[61:24];
        r_b_xlon <= w_plon[62:24];
        r_c_xd   <= w_pxd[56:16];
        r_c_ylat <= r_b_ylat;
        r_d_xs   <= w_pxs[65:20];
        r_d_ys   <= w_pys[62:20];
        r_e_p1   <= 64'(r_d_xs) * 64'(i_trig.cos_up);
        r_e_p2   <= 64'(r_d_ys) * 64'(i_trig.sin_up);
        r_e_p3   <= 64'(r_d_xs) * 64'(i_trig.sin_up);
        r_e_p4   <= 64'(r_d_ys) * 64'(i_trig.cos_up);
        r_f_rx   <= 65'(r_e_p1) - 65'(r_e_p2);
        r_f_ry   <= 65'(r_e_p3) + 65'(r_e_p4);
    end

    // Drop 32 fraction bits, rounding toward zero.
    assign w_ix = r_f_rx[64:32] + 33'((r_f_rx[64] && (r_f_rx[31:0] != '0)) ? 1 : 0);
    assign w_iy = r_f_ry[64:32] + 33'((r_f_ry[64] && (r_f_ry[31:0] != '0)) ? 1 : 0);
    assign w_sx = 35'(HALF_W) + 35'(w_ix);
    assign w_sy = 36'(HALF_H) - 36'(w_iy) + 36'(i_cfg.shift_down);

    always_comb begin
        w_sat_x = 1'b1;
        w_sat_y = 1'b1;
        priority if (w_sx > 35'sd32767) begin
            o_res.x = 16'sh7FFF;
        end else if (w_sx < -35'sd32768) begin
            o_res.x = -16'sh8000;
        end else begin
            o_res.x = w_sx[15:0];
            w_sat_x = 1'b0;
        end
        priority if (w_sy > 36'sd32767) begin
            o_res.y = 16'sh7FFF;
        end else if (w_sy < -36'sd32768) begin
            o_res.y = -16'sh8000;
        end else begin
            o_res.y = w_sy[15:0];
            w_sat_y = 1'b0;
        end
        o_res.sat = w_sat_x || w_sat_y;
    end

    assign o_res_push = r_vld[5];

endmodule

`default_nettype wire

// File: rtl/latlon_to_screen_xy_unit.sv
// Throughput: one point per cycle, set by the six-stage multiply pipeline,
// while the result queue has room and no trigonometry is pending.
// A write to the centre latitude or the up angle holds off points while
// the reciprocal phase step and the 30-step CORDIC run for each angle.
// Reset (synchronous, active low) empties both queues and restores the
// register defaults: centre 0/0, scale 1.0, up angle 0, shift 0.
// ============================================================================
// latlon_to_screen_xy_unit: GPS point to TFT screen projection
// Equirectangular projection with rotation, decoupled into an input front end
// and a pipelined back end joined by a short queue.
// ============================================================================
`default_nettype none

module latlon_to_screen_xy_unit #(
    parameter int SCREEN_W = 240,
    parameter int SCREEN_H = 320
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // Configuration port.
    input  wire                i_cfg_we,
    input  wire [2:0]          i_cfg_idx,
    input  wire [31:0]         i_cfg_data,
    // Point input, queue style.
    input  wire                push,
    output logic               full,
    input  wire signed [30:0]  i_point_latitude,
    input  wire signed [31:0]  i_point_longitude,
    // Result output, queue style.
    output logic               empty,
    input  wire                pop,
    output logic signed [15:0] o_screen_x,
    output logic signed [15:0] o_screen_y,
    output logic               o_saturated
);

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    // Configuration registers. Writes to the centre latitude and the up angle
    // also request a recomputation of the cached trigonometry.
    llxy_pkg::t_cfg  r_cfg;
    llxy_pkg::t_trig w_trig;
    logic            w_req_lat, w_req_up, w_trig_busy;

    assign w_req_lat = i_cfg_we && (i_cfg_idx == llxy_pkg::REG_CENTER_LAT);
    assign w_req_up  = i_cfg_we && (i_cfg_idx == llxy_pkg::REG_UP_DIR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_lat <= '0;
            r_cfg.center_lon <= '0;
            r_cfg.map_scale  <= 24'd1048576;
            r_cfg.up_dir     <= '0;
            r_cfg.shift_down <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                llxy_pkg::REG_CENTER_LAT: r_cfg.center_lat <= i_cfg_data[30:0];
                llxy_pkg::REG_CENTER_LON: r_cfg.center_lon <= i_cfg_data;
                llxy_pkg::REG_MAP_SCALE:  r_cfg.map_scale  <= i_cfg_data[23:0];
                llxy_pkg::REG_UP_DIR:     r_cfg.up_dir     <= i_cfg_data[11:0];
                llxy_pkg::REG_SHIFT_DOWN: r_cfg.shift_down <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    llxy_trig u_trig (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req_lat (w_req_lat),
        .i_req_up  (w_req_up),
        .i_cfg     (r_cfg),
        .o_trig    (w_trig),
        .o_busy    (w_trig_busy)
    );

    // Front end: every accepted transaction lands in the middle queue as a
    // pair of differences from the map centre.
    llxy_pkg::t_diff                w_fr_diff, w_bk_diff;
    logic                           w_mid_push, w_mid_pop, w_mid_full, w_mid_empty;
    logic [$clog2(MID_DEPTH):0]     w_mid_count;

    llxy_front u_front (
        .i_push            (push),
        .i_point_latitude  (i_point_latitude),
        .i_point_longitude (i_point_longitude),
        .i_cfg             (r_cfg),
        .i_trig_busy       (w_trig_busy),
        .i_q_full          (w_mid_full),
        .o_full            (full),
        .o_q_push          (w_mid_push),
        .o_diff            (w_fr_diff)
    );

    llxy_fifo #(
        .WIDTH ($bits(llxy_pkg::t_diff)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_fr_diff),
        .i_pop   (w_mid_pop),
        .o_data  (w_bk_diff),
        .o_full  (w_mid_full),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    // Back end: pulls from the middle queue only when the result queue has
    // a slot reserved for the transaction, so the pipeline never stalls.
    llxy_pkg::t_res             w_res, w_out_res;
    logic                       w_res_push, w_out_full;
    logic [$clog2(OUT_DEPTH):0] w_out_count;

    llxy_back #(
        .SCREEN_W  (SCREEN_W),
        .SCREEN_H  (SCREEN_H),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_diff      (w_bk_diff),
        .i_q_empty   (w_mid_empty),
        .o_q_pop     (w_mid_pop),
        .i_cfg       (r_cfg),
        .i_trig      (w_trig),
        .i_out_count (w_out_count),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    llxy_fifo #(
        .WIDTH ($bits(llxy_pkg::t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .i_pop   (pop),
        .o_data  (w_out_res),
        .o_full  (w_out_full),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign o_screen_x  = w_out_res.x;
    assign o_screen_y  = w_out_res.y;
    assign o_saturated = w_out_res.sat;

    // A trigonometry request must block new points from the next cycle on.
    a_trig_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_lat || w_req_up) |=> full)
        else $error("point input open while trigonometry is pending");

    // The credit scheme must keep the result queue from overflowing.
    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> (!w_out_full || (pop && !empty)))
        else $error("result queue overflow");

    // A clipped result has at least one coordinate at a range limit.
    a_sat_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_saturated) |->
            (o_screen_x == 16'sh7FFF || o_screen_x == -16'sh8000 ||
             o_screen_y == 16'sh7FFF || o_screen_y == -16'sh8000))
        else $error("saturated flag without a clipped coordinate");

    // The middle queue holds at most its depth.
    a_mid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_count <= ($clog2(MID_DEPTH)+1)'(MID_DEPTH))
        else $error("middle queue count out of range");

endmodule

`default_nettype wire
